[design/cblm_pkg.sv]
// Shared types, codes and constants of the CAN bus load and loss monitor.
package cblm_pkg;

    // Event kinds carried on the input tuser.
    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_REQ   = 2'd1;
    localparam logic [1:0] ACT_RESP  = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam int ACT_W     = 2;
    localparam int PAY_W     = 7;
    localparam int RATE_W    = 24;
    localparam int BITS_W    = 64;
    localparam int CNT_W     = 32;
    localparam int LOAD_W    = 16;
    localparam int LOSS_W    = 14;
    localparam int ADD_W     = 11;
    // Bit counts at or above 2^LOAD_BITS_W always saturate the load figure.
    localparam int LOAD_BITS_W = 27;
    localparam int LOAD_NUM_W  = LOAD_BITS_W + LOSS_W;

    // Shared divider: numerator, divisor and quotient widths.
    localparam int DIV_N_W = CNT_W + LOSS_W;
    localparam int DIV_D_W = CNT_W;
    localparam int DIV_Q_W = 16;

    localparam logic [RATE_W-1:0] BITRATE_RESET       = 24'd500000;
    localparam logic [ADD_W-1:0]  FRAME_OVERHEAD_BITS = 11'd40;
    localparam logic [LOSS_W-1:0] CENTI_SCALE         = 14'd10000;
    localparam logic [LOAD_W-1:0] LOAD_MAX            = 16'hFFFF;

    localparam logic DIV_SEL_LOAD = 1'b0;
    localparam logic DIV_SEL_LOSS = 1'b1;

    typedef struct packed {
        logic accept;
        logic prep;
        logic load_fix;
        logic div_start;
        logic div_sel;
        logic load_take;
        logic loss_mul;
        logic loss_fix;
        logic loss_take;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic load_sat;
        logic loss_zero;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

[design/cblm_div.sv]
// Restoring divider, one quotient bit per cycle, shared by load and loss.
module cblm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cblm_pkg::DIV_N_W-1:0] i_num,
    input  logic [cblm_pkg::DIV_D_W-1:0] i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [cblm_pkg::DIV_Q_W-1:0] o_quo
);
    localparam int QW    = cblm_pkg::DIV_Q_W;
    localparam int DW    = cblm_pkg::DIV_D_W;
    localparam int NW    = cblm_pkg::DIV_N_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_low;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient is known to fit QW bits, so the upper numerator part is below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num[NW-1:QW]);
            r_low <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_low <= {r_low[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding busy cycle");

endmodule

[design/cblm_dp.sv]
// Datapath: event counters, sliding window, load and loss arithmetic, result register.
module cblm_dp #(
    parameter int WINDOW_SECONDS    = 3,
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cblm_pkg::t_cmd                i_cmd,
    output cblm_pkg::t_stat               o_stat,
    input  logic [cblm_pkg::ACT_W-1:0]    i_action,
    input  logic [cblm_pkg::PAY_W-1:0]    i_payload,
    input  logic                          i_cfg_wr_en,
    input  logic [cblm_pkg::RATE_W-1:0]   i_cfg_wr_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [cblm_pkg::LOAD_W-1:0]   o_load,
    output logic [cblm_pkg::LOSS_W-1:0]   o_loss,
    output logic [cblm_pkg::CNT_W-1:0]    o_sent,
    output logic [cblm_pkg::CNT_W-1:0]    o_recv
);
    localparam int SLOT_W = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SECONDS - 1);
    localparam logic [cblm_pkg::PAY_W-1:0] PAY_MAX = cblm_pkg::PAY_W'(MAX_PAYLOAD_BYTES);
    localparam int BW  = cblm_pkg::BITS_W;
    localparam int CW  = cblm_pkg::CNT_W;
    localparam int LBW = cblm_pkg::LOAD_BITS_W;

    logic [cblm_pkg::RATE_W-1:0]     r_bitrate;
    logic [BW-1:0]                   r_bits;
    logic [CW-1:0]                   r_req;
    logic [CW-1:0]                   r_resp;
    logic [CW-1:0]                   r_req_win  [WINDOW_SECONDS];
    logic [CW-1:0]                   r_resp_win [WINDOW_SECONDS];
    logic [SLOT_W-1:0]               r_slot;
    logic [CW-1:0]                   r_sent;
    logic [CW-1:0]                   r_recv;
    logic [cblm_pkg::LOAD_NUM_W-1:0] r_load_num;
    logic                            r_load_sat;
    logic [CW-1:0]                   r_diff;
    logic                            r_loss_zero;
    logic [cblm_pkg::DIV_N_W-1:0]    r_loss_num;
    logic [cblm_pkg::LOAD_W-1:0]     r_load_res;
    logic [cblm_pkg::LOSS_W-1:0]     r_loss_res;
    logic                            r_out_valid;
    logic [cblm_pkg::LOAD_W-1:0]     r_out_load;
    logic [cblm_pkg::LOSS_W-1:0]     r_out_loss;
    logic [CW-1:0]                   r_out_sent;
    logic [CW-1:0]                   r_out_recv;

    logic [cblm_pkg::PAY_W-1:0]      w_pay;
    logic [cblm_pkg::ADD_W-1:0]      w_add;
    logic [BW:0]                     w_bits_sum;
    logic [cblm_pkg::LOAD_NUM_W-1:0] w_load_prod;
    logic [cblm_pkg::DIV_N_W-1:0]    w_div_num;
    logic [cblm_pkg::DIV_D_W-1:0]    w_div_den;
    logic                            w_div_busy;
    logic                            w_div_done;
    logic [cblm_pkg::DIV_Q_W-1:0]    w_div_quo;
    logic                            w_tick_acc;

    assign w_pay       = (i_payload > PAY_MAX) ? PAY_MAX : i_payload;
    assign w_add       = cblm_pkg::FRAME_OVERHEAD_BITS + {1'b0, w_pay, 3'b000};
    assign w_bits_sum  = {1'b0, r_bits} + (BW + 1)'(w_add);
    assign w_load_prod = r_bits[LBW-1:0] * cblm_pkg::CENTI_SCALE;
    assign w_tick_acc  = i_cmd.accept && (i_action == cblm_pkg::ACT_TICK);

    assign w_div_num = (i_cmd.div_sel == cblm_pkg::DIV_SEL_LOSS) ? r_loss_num
                     : cblm_pkg::DIV_N_W'(r_load_num);
    assign w_div_den = (i_cmd.div_sel == cblm_pkg::DIV_SEL_LOSS) ? r_sent
                     : cblm_pkg::DIV_D_W'(r_bitrate);

    cblm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Counters, window and running window sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitrate <= cblm_pkg::BITRATE_RESET;
            r_bits    <= '0;
            r_req     <= '0;
            r_resp    <= '0;
            r_slot    <= '0;
            r_sent    <= '0;
            r_recv    <= '0;
            for (int i = 0; i < WINDOW_SECONDS; i++) begin
                r_req_win[i]  <= '0;
                r_resp_win[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_bitrate <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                case (i_action)
                    cblm_pkg::ACT_FRAME: begin
                        r_bits <= w_bits_sum[BW] ? '1 : w_bits_sum[BW-1:0];
                    end
                    cblm_pkg::ACT_REQ: begin
                        r_req <= r_req + 1'b1;
                    end
                    cblm_pkg::ACT_RESP: begin
                        r_resp <= r_resp + 1'b1;
                    end
                    default: begin
                        // Retire the oldest slot from the sums and push this second in.
                        r_req_win[r_slot]  <= r_req;
                        r_resp_win[r_slot] <= r_resp;
                        r_sent <= r_sent - r_req_win[r_slot] + r_req;
                        r_recv <= r_recv - r_resp_win[r_slot] + r_resp;
                        r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                        r_bits <= '0;
                        r_req  <= '0;
                        r_resp <= '0;
                    end
                endcase
            end
        end
    end

    // Load and loss arithmetic.
    always_ff @(posedge i_clk) begin
        if (w_tick_acc) begin
            r_load_num <= w_load_prod;
            r_load_sat <= (r_bitrate == '0) || (|r_bits[BW-1:LBW]);
        end else if (i_cmd.prep) begin
            // Quotient would not fit 16 bits.
            if (r_load_num >= {1'b0, r_bitrate, 16'b0}) begin
                r_load_sat <= 1'b1;
            end
        end
        if (i_cmd.prep) begin
            r_diff      <= r_sent - r_recv;
            r_loss_zero <= !(r_sent > r_recv);
        end
        if (i_cmd.load_fix) begin
            r_load_res <= cblm_pkg::LOAD_MAX;
        end else if (i_cmd.load_take) begin
            r_load_res <= w_div_quo;
        end
        if (i_cmd.loss_mul) begin
            r_loss_num <= r_diff * cblm_pkg::CENTI_SCALE;
        end
        if (i_cmd.loss_fix) begin
            r_loss_res <= '0;
        end else if (i_cmd.loss_take) begin
            r_loss_res <= w_div_quo[cblm_pkg::LOSS_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_load <= r_load_res;
            r_out_loss <= r_loss_res;
            r_out_sent <= r_sent;
            r_out_recv <= r_recv;
        end
    end

    assign o_stat.is_tick   = (i_action == cblm_pkg::ACT_TICK);
    assign o_stat.load_sat  = r_load_sat;
    assign o_stat.loss_zero = r_loss_zero;
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_load      = r_out_load;
    assign o_loss      = r_out_loss;
    assign o_sent      = r_out_sent;
    assign o_recv      = r_out_recv;

    a_loss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_loss <= cblm_pkg::LOSS_W'(10000)))
        else $error("loss result above one hundred percent");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_acc |=> (r_bits == '0 && r_req == '0 && r_resp == '0))
        else $error("per-second counters not cleared after tick");

endmodule

[design/cblm_ctrl.sv]
// Controller: sequences a tick through load division, loss division and result hand-off.
module cblm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cblm_pkg::t_stat i_stat,
    output cblm_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_LWAIT = 3'd3;
    localparam logic [2:0] S_LMUL  = 3'd4;
    localparam logic [2:0] S_LOSS  = 3'd5;
    localparam logic [2:0] S_SWAIT = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.is_tick) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.load_sat) begin
                    o_cmd.load_fix = 1'b1;
                    n_state        = S_LMUL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = cblm_pkg::DIV_SEL_LOAD;
                    n_state         = S_LWAIT;
                end
            end
            S_LWAIT: begin
                o_cmd.div_sel = cblm_pkg::DIV_SEL_LOAD;
                if (i_stat.div_done) begin
                    o_cmd.load_take = 1'b1;
                    n_state         = S_LMUL;
                end
            end
            S_LMUL: begin
                o_cmd.loss_mul = 1'b1;
                n_state        = S_LOSS;
            end
            S_LOSS: begin
                o_cmd.div_sel = cblm_pkg::DIV_SEL_LOSS;
                if (i_stat.loss_zero) begin
                    o_cmd.loss_fix = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_SWAIT;
                end
            end
            S_SWAIT: begin
                o_cmd.div_sel = cblm_pkg::DIV_SEL_LOSS;
                if (i_stat.div_done) begin
                    o_cmd.loss_take = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the result register is free or being drained.
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");

endmodule

[design/can_bus_load_and_loss_monitor_top.sv]
// Top level of the CAN bus load and request loss monitor.
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: payload bytes
//  m_axis    out  m_axis_tvalid / m_axis_tready  load, loss, window sums (one per tick)
//  cfg       in   i_cfg_wr_en                    bus bit rate
//
// Frame, request and response events are accepted without leaving the idle state.
// A tick runs up to two 16-step passes of the shared divider (load, then loss; a pass is
// skipped when its result saturates or is zero) plus setup states; the next item waits for it.
// Reset is synchronous, active low; it clears counters and the window.
// A tick whose result finds the output register still full waits for m_axis_tready.
module can_bus_load_and_loss_monitor_top #(
    parameter int WINDOW_SECONDS    = 3,
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] payload_bytes, [7] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [15:0] load_centipercent, [29:16] loss_centipercent,
                                        // [61:30] sent_in_window, [93:62] received_in_window,
                                        // [95:94] zero
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data
);
    cblm_pkg::t_cmd  w_cmd;
    cblm_pkg::t_stat w_stat;

    logic [cblm_pkg::LOAD_W-1:0] w_load;
    logic [cblm_pkg::LOSS_W-1:0] w_loss;
    logic [cblm_pkg::CNT_W-1:0]  w_sent;
    logic [cblm_pkg::CNT_W-1:0]  w_recv;

    cblm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cblm_dp #(
        .WINDOW_SECONDS    (WINDOW_SECONDS),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (s_axis_tuser),
        .i_payload     (s_axis_tdata[6:0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_load        (w_load),
        .o_loss        (w_loss),
        .o_sent        (w_sent),
        .o_recv        (w_recv)
    );

    assign m_axis_tdata = {2'b00, w_recv, w_sent, w_loss, w_load};

endmodule

[tb/can_bus_load_and_loss_monitor_top_tb.sv]
// Self-checking testbench for the CAN bus load and request loss monitor.
`timescale 1ns / 100ps

module can_bus_load_and_loss_monitor_top_tb;

    localparam int WINDOW_SECONDS    = 3;
    localparam int MAX_PAYLOAD_BYTES = 64;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int SETTLE_CYCLES     = 64;
    localparam int HOLD_CYCLES       = 1000;
    localparam int RAND_PHASES       = 7;
    localparam int ITEMS_PER_PHASE   = 140;
    localparam int MAX_REPORTED      = 10;
    localparam logic [cblm_pkg::PAY_W-1:0] PAY_LIMIT = cblm_pkg::PAY_W'(MAX_PAYLOAD_BYTES);

    typedef struct packed {
        logic [cblm_pkg::LOAD_W-1:0] load;
        logic [cblm_pkg::LOSS_W-1:0] loss;
        logic [cblm_pkg::CNT_W-1:0]  sent;
        logic [cblm_pkg::CNT_W-1:0]  recv;
    } t_tick_report;

    typedef enum logic {ROW_EVENT, ROW_RATE} t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [cblm_pkg::ACT_W-1:0]  act;
        logic [cblm_pkg::PAY_W-1:0]  pay;
        logic [cblm_pkg::RATE_W-1:0] rate;
        logic                        pinned;
        t_tick_report                rep;
    } t_stim_row;

    localparam int N_ROWS = 27;
    localparam t_tick_report NO_REP   = '{16'd0, 14'd0, 32'd0, 32'd0};
    localparam t_tick_report SAT_LOAD = '{cblm_pkg::LOAD_MAX, 14'd0, 32'd0, 32'd0};

    // Only pinned rows carry a typed report; the rest are predicted.
    t_stim_row dir_rows [N_ROWS] = '{
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b1, NO_REP},  // after reset
        '{ROW_EVENT, cblm_pkg::ACT_FRAME, 7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_FRAME, 7'd64,  24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_FRAME, 7'd127, 24'd0,        1'b0, NO_REP},  // oversized
        '{ROW_EVENT, cblm_pkg::ACT_FRAME, 7'd65,  24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_REQ,   7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_REQ,   7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_RESP,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_RESP,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_RESP,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_RESP,  7'd0,   24'd0,        1'b0, NO_REP},
        // more responses than requests; window now full
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_REQ,   7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},  // oldest slot
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_REQ,   7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},  // full loss
        '{ROW_RATE,  cblm_pkg::ACT_FRAME, 7'd0,   24'd1,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b0, NO_REP},  // drained
        '{ROW_EVENT, cblm_pkg::ACT_FRAME, 7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b1, SAT_LOAD}, // overflow
        '{ROW_RATE,  cblm_pkg::ACT_FRAME, 7'd0,   24'd0,        1'b0, NO_REP},
        '{ROW_EVENT, cblm_pkg::ACT_TICK,  7'd0,   24'd0,        1'b1, SAT_LOAD}, // zero rate
        '{ROW_RATE,  cblm_pkg::ACT_FRAME, 7'd0,   24'd16000000, 1'b0, NO_REP}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [6:0] payload_bytes, [7] zero
    logic [1:0]  s_axis_tuser;   // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // [15:0] load, [29:16] loss, [61:30] sent, [93:62] received
    logic        i_cfg_wr_en;
    logic [23:0] i_cfg_wr_data;

    // Predicted block state
    logic [cblm_pkg::RATE_W-1:0] rate_model = cblm_pkg::BITRATE_RESET;
    logic [cblm_pkg::BITS_W-1:0] bit_total  = '0;
    logic [cblm_pkg::CNT_W-1:0]  req_count  = '0;
    logic [cblm_pkg::CNT_W-1:0]  resp_count = '0;
    logic [cblm_pkg::CNT_W-1:0]  req_win  [WINDOW_SECONDS] = '{default: '0};
    logic [cblm_pkg::CNT_W-1:0]  resp_win [WINDOW_SECONDS] = '{default: '0};
    int                          win_slot   = 0;

    t_tick_report due_reports [$];
    t_tick_report pin_rep;
    bit           pin_use = 1'b0;
    bit           run_flat = 1'b0;
    bit           hold_req = 1'b0;
    bit           hold_seen = 1'b0;
    int           hold_left = 0;
    int           fail_count = 0;
    int           events_seen = 0;
    int           reports_seen = 0;
    int           items_sent = 0;
    int           rates_written = 0;
    int           cycle_count = 0;

    can_bus_load_and_loss_monitor_top #(
        .WINDOW_SECONDS   (WINDOW_SECONDS),
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Update the predicted counters; returns 1 when a tick report is due.
    function automatic bit apply_bus_event(input logic [cblm_pkg::ACT_W-1:0] act,
                                           input logic [cblm_pkg::PAY_W-1:0] pay,
                                           output t_tick_report rep);
        logic [cblm_pkg::PAY_W-1:0]  p;
        logic [cblm_pkg::BITS_W-1:0] add;
        logic [63:0]                 scaled;
        logic [63:0]                 quot;
        logic [63:0]                 lost;
        logic [cblm_pkg::CNT_W-1:0]  sent;
        logic [cblm_pkg::CNT_W-1:0]  recv;
        rep = NO_REP;
        case (act)
            cblm_pkg::ACT_FRAME: begin
                p = (pay > PAY_LIMIT) ? PAY_LIMIT : pay;
                add = {53'd0, cblm_pkg::FRAME_OVERHEAD_BITS} + {54'd0, p, 3'b000};
                if (bit_total > ~add) bit_total = '1;
                else bit_total = bit_total + add;
                return 1'b0;
            end
            cblm_pkg::ACT_REQ: begin
                req_count = req_count + 1'b1;
                return 1'b0;
            end
            cblm_pkg::ACT_RESP: begin
                resp_count = resp_count + 1'b1;
                return 1'b0;
            end
            default: begin
                if (rate_model == '0 ||
                    bit_total > 64'hFFFF_FFFF_FFFF_FFFF / {50'd0, cblm_pkg::CENTI_SCALE}) begin
                    rep.load = cblm_pkg::LOAD_MAX;
                end else begin
                    scaled = bit_total * {50'd0, cblm_pkg::CENTI_SCALE};
                    quot = scaled / {40'd0, rate_model};
                    rep.load = (quot > {48'd0, cblm_pkg::LOAD_MAX}) ? cblm_pkg::LOAD_MAX
                             : quot[cblm_pkg::LOAD_W-1:0];
                end
                req_win[win_slot]  = req_count;
                resp_win[win_slot] = resp_count;
                win_slot = (win_slot + 1) % WINDOW_SECONDS;
                sent = '0;
                recv = '0;
                for (int i = 0; i < WINDOW_SECONDS; i++) begin
                    sent = sent + req_win[i];
                    recv = recv + resp_win[i];
                end
                if (sent != '0 && sent > recv) begin
                    lost = {32'd0, sent - recv} * {50'd0, cblm_pkg::CENTI_SCALE};
                    lost = lost / {32'd0, sent};
                    rep.loss = lost[cblm_pkg::LOSS_W-1:0];
                end
                rep.sent = sent;
                rep.recv = recv;
                bit_total  = '0;
                req_count  = '0;
                resp_count = '0;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [cblm_pkg::PAY_W-1:0] rand_payload();
        if ($urandom_range(0, 99) < 90)
            return cblm_pkg::PAY_W'($urandom_range(0, MAX_PAYLOAD_BYTES));
        return cblm_pkg::PAY_W'($urandom_range(MAX_PAYLOAD_BYTES + 1, 127));
    endfunction

    // Offer one event and hold it until the transfer.
    task automatic send_item(input logic [cblm_pkg::ACT_W-1:0] act,
                             input logic [cblm_pkg::PAY_W-1:0] pay);
        while (!run_flat && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, pay};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drain every pending report, let the block settle, then load a new bit rate.
    task automatic write_rate(input logic [cblm_pkg::RATE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        rates_written++;
    endtask

    // Receiver: random back-pressure, a flat stretch and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= run_flat || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        t_tick_report got;
        t_tick_report want;
        t_tick_report predicted;
        if (i_rst_n) begin
            if (i_cfg_wr_en) rate_model = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                events_seen++;
                if (apply_bus_event(s_axis_tuser, s_axis_tdata[cblm_pkg::PAY_W-1:0],
                                    predicted))
                    due_reports.push_back(pin_use ? pin_rep : predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                reports_seen++;
                got = '{m_axis_tdata[15:0], m_axis_tdata[29:16],
                        m_axis_tdata[61:30], m_axis_tdata[93:62]};
                if (due_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED)
                        $display("unexpected report: load %0d loss %0d sent %0d recv %0d",
                                 got.load, got.loss, got.sent, got.recv);
                end else begin
                    want = due_reports.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTED)
                            $display("report %0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     reports_seen, want.load, want.loss, want.sent,
                                     want.recv, got.load, got.loss, got.sent, got.recv);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reports pending", cycle_count,
                 due_reports.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int          target;
        int          n;
        int          drop;
        logic [23:0] rate;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cblm_pkg::ACT_FRAME;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        pin_rep       = NO_REP;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_RATE) begin
                write_rate(dir_rows[r].rate);
            end else begin
                pin_use = dir_rows[r].pinned;
                pin_rep = dir_rows[r].rep;
                send_item(dir_rows[r].act, dir_rows[r].pay);
            end
        end
        pin_use = 1'b0;

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: rate = cblm_pkg::BITRATE_RESET;
                1: rate = 24'($urandom_range(1000, 50000));
                2: rate = 24'hFFFFFF;
                3: rate = 24'($urandom_range(1, 200));
                4: rate = 24'd16000000;
                5: rate = 24'd0;
                default: rate = 24'($urandom_range(1, 24'hFFFFFF));
            endcase
            write_rate(rate);
            run_flat = (phase == 1);
            // Stall the output long enough for reports to back up into the input.
            if (phase == 3) hold_req = ~hold_req;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 85) begin
                    // One bus second: frames and request/response pairs, some lost.
                    n = $urandom_range(0, 16);
                    drop = $urandom_range(0, 100);
                    repeat (n) begin
                        if ($urandom_range(0, 2) == 0) begin
                            send_item(cblm_pkg::ACT_FRAME, rand_payload());
                        end else begin
                            send_item(cblm_pkg::ACT_REQ, rand_payload());
                            if ($urandom_range(0, 99) >= drop)
                                send_item(cblm_pkg::ACT_RESP, rand_payload());
                        end
                    end
                    send_item(cblm_pkg::ACT_TICK, rand_payload());
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(cblm_pkg::ACT_W'($urandom_range(0, 3)),
                                  cblm_pkg::PAY_W'($urandom_range(0, 127)));
                end
            end
        end
        run_flat = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Covered %0d bus events and %0d tick reports over %0d bit-rate settings,",
                 events_seen, reports_seen, rates_written + 1);
        $display("including zero, unit and full-scale rates and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (fail_count == 0 && due_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d reports missing", fail_count, due_reports.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
